// ===== design/u8v_pkg.sv =====
`default_nettype none

package u8v_pkg;

   localparam logic [1:0] VERDICT_OPEN    = 2'd0;
   localparam logic [1:0] VERDICT_VALID   = 2'd1;
   localparam logic [1:0] VERDICT_INVALID = 2'd2;

   localparam logic [7:0]  LEAD2_LO     = 8'hc2;
   localparam logic [7:0]  LEAD2_HI     = 8'hdf;
   localparam logic [7:0]  LEAD3_LO     = 8'he0;
   localparam logic [7:0]  LEAD3_HI     = 8'hef;
   localparam logic [7:0]  LEAD4_LO     = 8'hf0;
   localparam logic [7:0]  LEAD4_HI     = 8'hf4;
   localparam logic [20:0] CP_MAX       = 21'h10ffff;
   localparam logic [20:0] SURR_LO      = 21'h00d800;
   localparam logic [20:0] SURR_HI      = 21'h00dfff;
   localparam logic [20:0] MIN_CLASS1   = 21'h000080;
   localparam logic [20:0] MIN_CLASS2   = 21'h000800;
   localparam logic [20:0] MIN_CLASS3   = 21'h010000;
   localparam logic [1:0]  CONT_TAG     = 2'b10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
      logic       empty_string;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic       final_res;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  tail_remaining;
      logic [20:0] code_accum;
      logic [1:0]  lead_class;
      logic        error_seen;
   } state_type;

endpackage

`default_nettype wire

// ===== design/utf8_stream_validator.sv =====
// Strict UTF-8 checker, one byte per word, one result word per byte, a new byte
// taken every cycle while req_stall is low. The decoder state and the result are
// updated in the cycle a byte is taken; the result is held in an output register,
// backed by a one-word skid stage so a stalled result side does not stall the
// input until both are full. Each result carries a running verdict; the byte
// flagged end_of_string closes the string with the final verdict and clears the
// state, and empty_string closes it at once as valid.
`default_nettype none

module utf8_stream_validator (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire u8v_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output u8v_pkg::rsp_type      rsp_data
);

   u8v_pkg::state_type st_ff, st_in;
   u8v_pkg::rsp_type   res;
   u8v_pkg::rsp_type   out_ff, out_in, skid_ff, skid_in;
   logic               out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic               take, pop;

   u8v_step u_step (
      .req (req_data),
      .cur (st_ff),
      .nxt (st_in),
      .rsp (res)
   );

   assign req_stall = skid_vld_ff;
   assign take      = req_valid && !skid_vld_ff;
   assign pop       = out_vld_ff && !rsp_stall;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (!out_vld_ff || pop) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = res;
            out_vld_in = take;
         end
      end else if (take) begin
         skid_in     = res;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (take) begin
            st_ff <= st_in;
         end
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// ===== design/u8v_step.sv =====
`default_nettype none

module u8v_step (
   input  wire u8v_pkg::req_type   req,
   input  wire u8v_pkg::state_type cur,
   output u8v_pkg::state_type      nxt,
   output u8v_pkg::rsp_type        rsp
);

   u8v_pkg::state_type tk;
   logic [20:0]        acc;
   logic [20:0]        cls_min;
   logic [7:0]         b;
   logic               bad;

   assign b   = req.data_byte;
   assign acc = {cur.code_accum[14:0], b[5:0]};

   always_comb begin
      case (cur.lead_class)
         2'd1:    cls_min = u8v_pkg::MIN_CLASS1;
         2'd2:    cls_min = u8v_pkg::MIN_CLASS2;
         default: cls_min = u8v_pkg::MIN_CLASS3;
      endcase
   end

   // one byte through the decoder
   always_comb begin
      tk = cur;
      if (!cur.error_seen) begin
         if (cur.tail_remaining == 2'd0) begin
            if (b == 8'd0) begin
               tk.error_seen = 1'b1;
            end else if (b[7] == 1'b0) begin
               tk = cur;
            end else if (b >= u8v_pkg::LEAD2_LO && b <= u8v_pkg::LEAD2_HI) begin
               tk.tail_remaining = 2'd1;
               tk.lead_class     = 2'd1;
               tk.code_accum     = {16'd0, b[4:0]};
            end else if (b >= u8v_pkg::LEAD3_LO && b <= u8v_pkg::LEAD3_HI) begin
               tk.tail_remaining = 2'd2;
               tk.lead_class     = 2'd2;
               tk.code_accum     = {17'd0, b[3:0]};
            end else if (b >= u8v_pkg::LEAD4_LO && b <= u8v_pkg::LEAD4_HI) begin
               tk.tail_remaining = 2'd3;
               tk.lead_class     = 2'd3;
               tk.code_accum     = {18'd0, b[2:0]};
            end else begin
               tk.error_seen = 1'b1;
            end
         end else if (b[7:6] != u8v_pkg::CONT_TAG) begin
            tk.error_seen     = 1'b1;
            tk.tail_remaining = 2'd0;
         end else begin
            tk.code_accum     = acc;
            tk.tail_remaining = cur.tail_remaining - 2'd1;
            if (cur.tail_remaining == 2'd1) begin
               if (acc < cls_min || acc > u8v_pkg::CP_MAX ||
                   (acc >= u8v_pkg::SURR_LO && acc <= u8v_pkg::SURR_HI)) begin
                  tk.error_seen = 1'b1;
               end
               tk.code_accum = '0;
               tk.lead_class = 2'd0;
            end
         end
      end
   end

   assign bad = tk.error_seen || (tk.tail_remaining != 2'd0);

   always_comb begin
      nxt = tk;
      rsp.final_res = 1'b0;
      rsp.verdict   = tk.error_seen ? u8v_pkg::VERDICT_INVALID : u8v_pkg::VERDICT_OPEN;
      if (req.empty_string) begin
         nxt           = '0;
         rsp.final_res = 1'b1;
         rsp.verdict   = u8v_pkg::VERDICT_VALID;
      end else if (req.end_of_string) begin
         nxt           = '0;
         rsp.final_res = 1'b1;
         rsp.verdict   = bad ? u8v_pkg::VERDICT_INVALID : u8v_pkg::VERDICT_VALID;
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_utf8_stream_validator.sv =====
module tb_utf8_stream_validator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1600;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 10;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   u8v_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   u8v_pkg::rsp_type rsp_data;

   u8v_pkg::req_type byte_q[$];
   u8v_pkg::rsp_type verdict_q[$];
   logic [7:0]       txt[$];

   int total_words;
   int taken_words;
   int error_cnt;
   int quiet_cycles;
   int tx_idle;
   int rx_idle;
   bit tx_calm;
   bit rx_calm;

   // mirror of the decoder state
   logic [1:0]  tail_left;
   logic [20:0] cp_acc;
   logic [1:0]  seq_class;
   logic        err_flag;

   utf8_stream_validator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int idle_len(input bit calm);
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 55) begin
         return 0;
      end
      if (p < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 25);
   endfunction

   task automatic clear_track();
      tail_left = '0;
      cp_acc    = '0;
      seq_class = '0;
      err_flag  = 1'b0;
   endtask

   task automatic track_utf8(input u8v_pkg::req_type w);
      u8v_pkg::rsp_type r;
      logic [7:0]       b;
      logic [20:0]      floor_cp;
      b = w.data_byte;
      if (w.empty_string) begin
         clear_track();
         r.verdict   = u8v_pkg::VERDICT_VALID;
         r.final_res = 1'b1;
      end else begin
         if (!err_flag) begin
            if (tail_left == 2'd0) begin
               if (b == 8'h00) begin
                  err_flag = 1'b1;
               end else if (b < 8'h80) begin
               end else if (b >= u8v_pkg::LEAD2_LO && b <= u8v_pkg::LEAD2_HI) begin
                  tail_left = 2'd1;
                  seq_class = 2'd1;
                  cp_acc    = {16'd0, b[4:0]};
               end else if (b >= u8v_pkg::LEAD3_LO && b <= u8v_pkg::LEAD3_HI) begin
                  tail_left = 2'd2;
                  seq_class = 2'd2;
                  cp_acc    = {17'd0, b[3:0]};
               end else if (b >= u8v_pkg::LEAD4_LO && b <= u8v_pkg::LEAD4_HI) begin
                  tail_left = 2'd3;
                  seq_class = 2'd3;
                  cp_acc    = {18'd0, b[2:0]};
               end else begin
                  err_flag = 1'b1;
               end
            end else if (b[7:6] != u8v_pkg::CONT_TAG) begin
               err_flag  = 1'b1;
               tail_left = 2'd0;
            end else begin
               cp_acc    = {cp_acc[14:0], b[5:0]};
               tail_left = tail_left - 2'd1;
               if (tail_left == 2'd0) begin
                  floor_cp = (seq_class == 2'd1) ? u8v_pkg::MIN_CLASS1 :
                             (seq_class == 2'd2) ? u8v_pkg::MIN_CLASS2 :
                                                   u8v_pkg::MIN_CLASS3;
                  if (cp_acc < floor_cp || cp_acc > u8v_pkg::CP_MAX ||
                      (cp_acc >= u8v_pkg::SURR_LO && cp_acc <= u8v_pkg::SURR_HI)) begin
                     err_flag = 1'b1;
                  end
                  cp_acc    = '0;
                  seq_class = '0;
               end
            end
         end
         if (w.end_of_string) begin
            r.verdict   = (err_flag || tail_left != 2'd0) ? u8v_pkg::VERDICT_INVALID :
                                                            u8v_pkg::VERDICT_VALID;
            r.final_res = 1'b1;
            clear_track();
         end else begin
            r.verdict   = err_flag ? u8v_pkg::VERDICT_INVALID : u8v_pkg::VERDICT_OPEN;
            r.final_res = 1'b0;
         end
      end
      verdict_q.push_back(r);
   endtask

   // queue the bytes in txt, marking the last one when shut is set
   task automatic put_text(input bit shut);
      u8v_pkg::req_type w;
      for (int i = 0; i < txt.size(); i++) begin
         w.data_byte     = txt[i];
         w.end_of_string = shut && (i == txt.size() - 1);
         w.empty_string  = 1'b0;
         byte_q.push_back(w);
      end
      txt.delete();
   endtask

   task automatic add_empty();
      u8v_pkg::req_type w;
      w.data_byte     = 8'($urandom_range(0, 255));
      w.end_of_string = 1'($urandom_range(0, 1));
      w.empty_string  = 1'b1;
      byte_q.push_back(w);
   endtask

   task automatic put_cp(input logic [20:0] cp, input int n);
      case (n)
         1: begin
            txt.push_back({1'b0, cp[6:0]});
         end
         2: begin
            txt.push_back({3'b110, cp[10:6]});
            txt.push_back({u8v_pkg::CONT_TAG, cp[5:0]});
         end
         3: begin
            txt.push_back({4'b1110, cp[15:12]});
            txt.push_back({u8v_pkg::CONT_TAG, cp[11:6]});
            txt.push_back({u8v_pkg::CONT_TAG, cp[5:0]});
         end
         default: begin
            txt.push_back({5'b11110, cp[20:18]});
            txt.push_back({u8v_pkg::CONT_TAG, cp[17:12]});
            txt.push_back({u8v_pkg::CONT_TAG, cp[11:6]});
            txt.push_back({u8v_pkg::CONT_TAG, cp[5:0]});
         end
      endcase
   endtask

   task automatic put_good_cp(input int n);
      logic [20:0] cp;
      case (n)
         1:       cp = 21'($urandom_range(1, 'h7f));
         2:       cp = 21'($urandom_range('h80, 'h7ff));
         3: begin
            cp = 21'($urandom_range('h800, 'hffff));
            if (cp >= u8v_pkg::SURR_LO && cp <= u8v_pkg::SURR_HI) begin
               cp = cp ^ 21'h008000;
            end
         end
         default: cp = 21'($urandom_range('h10000, 'h10ffff));
      endcase
      put_cp(cp, n);
   endtask

   task automatic add_char();
      int          p;
      int          n;
      int          k;
      logic [7:0]  b;
      logic [20:0] edges[8];
      edges = '{21'h80, 21'h7ff, 21'h800, 21'hffff, 21'hd7ff, 21'he000, 21'h10000,
                21'h10ffff};
      p = $urandom_range(0, 99);
      if (p < 20) begin
         put_good_cp(1);
      end else if (p < 65) begin
         put_good_cp(2 + (p - 20) / 15);
      end else if (p < 70) begin
         k = $urandom_range(0, 7);
         put_cp(edges[k], (k < 2) ? 2 : (k < 6) ? 3 : 4);
      end else if (p < 75) begin
         n = $urandom_range(2, 4);
         put_cp(21'($urandom_range(0, (n == 2) ? 'h7f : (n == 3) ? 'h7ff : 'hffff)), n);
      end else if (p < 79) begin
         put_cp(21'($urandom_range(u8v_pkg::SURR_LO, u8v_pkg::SURR_HI)), 3);
      end else if (p < 83) begin
         put_cp(21'($urandom_range('h110000, 'h1fffff)), 4);
      end else if (p < 87) begin
         n = $urandom_range(2, 4);
         put_good_cp(n);
         k = $urandom_range(1, n - 1);
         repeat (k) void'(txt.pop_back());
      end else if (p < 91) begin
         n = $urandom_range(2, 4);
         put_good_cp(n);
         b = 8'($urandom_range(0, 255));
         if (b[7:6] == u8v_pkg::CONT_TAG) begin
            b[6] = 1'b1;
         end
         txt[txt.size() - $urandom_range(1, n - 1)] = b;
      end else if (p < 93) begin
         txt.push_back(8'h00);
      end else if (p < 97) begin
         txt.push_back(8'($urandom_range('h80, 'hbf)));
      end else begin
         txt.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int nchar;
      clear_track();
      tx_calm = 1'b0;
      rx_calm = 1'b0;

      add_empty();
      txt = '{8'h41, 8'h7f};               put_text(1'b1);
      txt = '{8'h00};                      put_text(1'b1);
      txt = '{8'hc2, 8'h80};               put_text(1'b1);
      txt = '{8'he0, 8'h9f, 8'hbf};        put_text(1'b1);
      txt = '{8'hed, 8'ha0, 8'h80};        put_text(1'b1);
      txt = '{8'hf4, 8'h90, 8'h80, 8'h80}; put_text(1'b1);
      txt = '{8'hf4, 8'h8f, 8'hbf, 8'hbf}; put_text(1'b1);
      txt = '{8'hff};                      put_text(1'b1);
      txt = '{8'he2, 8'h82};               put_text(1'b1);
      txt = '{8'hc2, 8'h41, 8'h42};        put_text(1'b1);
      txt = '{8'hc2};                      put_text(1'b0);
      add_empty();
      txt = '{8'h80};                      put_text(1'b1);

      while (byte_q.size() < RANDOM_WORDS + 29) begin
         if ($urandom_range(0, 99) < 4) begin
            add_empty();
         end else begin
            nchar = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            repeat (nchar) add_char();
            if ($urandom_range(0, 99) < 3) begin
               put_text(1'b0);
               add_empty();
            end else begin
               put_text(1'b1);
            end
         end
      end
      total_words = byte_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (taken_words != total_words);
      do @(negedge clock); while (verdict_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_cnt == 0 && verdict_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         tx_idle = 0;
      end else begin
         if (req_valid && !req_stall) begin
            track_utf8(req_data);
            taken_words++;
         end
         if (!req_valid || !req_stall) begin
            if (tx_idle > 0) begin
               tx_idle--;
               req_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
               req_data  <= byte_q.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 149) == 0) begin
                  tx_calm = !tx_calm;
               end
               tx_idle = idle_len(tx_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      u8v_pkg::rsp_type exp_rsp;
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_idle = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected word, got verdict %0d final %0b", $time,
                        rsp_data.verdict, rsp_data.final_res);
               error_cnt++;
            end else begin
               exp_rsp = verdict_q.pop_front();
               if (rsp_data.verdict !== exp_rsp.verdict) begin
                  $display("%0t: verdict expected %0d got %0d", $time,
                           exp_rsp.verdict, rsp_data.verdict);
                  error_cnt++;
               end
               if (rsp_data.final_res !== exp_rsp.final_res) begin
                  $display("%0t: final_res expected %0b got %0b", $time,
                           exp_rsp.final_res, rsp_data.final_res);
                  error_cnt++;
               end
            end
         end
         if (rx_idle > 0) begin
            rsp_stall <= 1'b1;
            rx_idle--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 149) == 0) begin
               rx_calm = !rx_calm;
            end
            rx_idle = idle_len(rx_calm);
         end
      end
   end

   // nothing moving on either side for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== files.f =====
design/u8v_pkg.sv
design/u8v_step.sv
design/utf8_stream_validator.sv
tb/tb_utf8_stream_validator.sv
